FILE: rtl/lbs_pkg.sv
// Shared types, constants and helper functions for the LED blink speed controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lbs_pkg;

    localparam int LINE_MAX_DEF  = 64;
    localparam int TIME_BITS_DEF = 32;
    // Command queue depth between front and back; keep it a power of two.
    localparam int QUEUE_DEPTH   = 2;

    localparam int CFG_WIDTH = 16;

    localparam logic [CFG_WIDTH-1:0] SLOW_PERIOD_RST = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] MID_PERIOD_RST  = 16'd500;
    localparam logic [CFG_WIDTH-1:0] FAST_PERIOD_RST = 16'd100;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST    = 16'd20;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_PRESS = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;

    localparam int NUM_SPEEDS = 3;

    typedef enum logic [1:0] {
        REG_SLOW_PERIOD = 2'd0,
        REG_MID_PERIOD  = 2'd1,
        REG_FAST_PERIOD = 2'd2,
        REG_DEBOUNCE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SPEED_SLOW = 2'd0,
        SPEED_MID  = 2'd1,
        SPEED_FAST = 2'd2
    } speed_t;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_PRESS = 2'd1,
        CMD_BYTE  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } lbs_in_t;

    typedef struct packed {
        logic       led_on;
        logic [1:0] speed_code;
        logic       led_toggled;
        logic       line_ended;
    } lbs_out_t;

    // Classified word handed from front to back.
    typedef struct packed {
        cmd_kind_t kind;
        logic      set_speed;
        speed_t    speed;
        logic      ended;
    } lbs_cmd_t;

    function automatic logic [2:0] word_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            2'd0:    len = 3'd4;
            2'd1:    len = 3'd3;
            2'd2:    len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Characters of "slow", "mid", "fast" in speed order.
    function automatic logic [7:0] word_char(input logic [1:0] k, input logic [1:0] idx);
        logic [7:0] ch;
        unique case ({k, idx})
            4'b00_00: ch = "s";
            4'b00_01: ch = "l";
            4'b00_10: ch = "o";
            4'b00_11: ch = "w";
            4'b01_00: ch = "m";
            4'b01_01: ch = "i";
            4'b01_10: ch = "d";
            4'b10_00: ch = "f";
            4'b10_01: ch = "a";
            4'b10_10: ch = "s";
            4'b10_11: ch = "t";
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic speed_t next_speed(input speed_t s);
        speed_t n;
        unique case (s)
            SPEED_SLOW: n = SPEED_MID;
            SPEED_MID:  n = SPEED_FAST;
            default:    n = SPEED_SLOW;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/led_blink_speed_controller.sv
// LED blink speed controller, top level: front end, command queue, back end.
// A word goes into the queue; the back end retires it from there and registers its result.
// Throughput: one word per cycle, but a result held by out_ready low stalls the back end.
// Input stays ready while the two-entry queue has room, also while a result waits.
// Reset (rst_n, asynchronous, active low): LED off, slow speed, counts cleared,
// line empty, periods 1000/500/100 and debounce 20 ticks.
`default_nettype none

module led_blink_speed_controller
    import lbs_pkg::*;
#(
    parameter int LINE_MAX  = LINE_MAX_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_idx,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lbs_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lbs_out_t                  out_data
);

    logic     push_valid, push_ready;
    lbs_cmd_t push_cmd;
    logic     pop_valid, pop_ready;
    lbs_cmd_t pop_cmd;

    assign in_ready = push_ready;

    lbs_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    lbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    lbs_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_ready (pop_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

FILE: rtl/lbs_front.sv
// Front end: classifies input words and tracks the serial command line.
// Depends on lbs_pkg.
`default_nettype none

module lbs_front
    import lbs_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire lbs_in_t  in_data,
    input  wire logic     push_ready,
    output logic          push_valid,
    output lbs_cmd_t      push_cmd
);

    localparam int LW = $clog2(LINE_MAX + 1);

    logic [LW-1:0] line_len_reg, line_len_next;
    logic [2:0]    flags_reg, flags_next;
    logic          is_term;
    logic          take;

    assign take       = in_valid && push_ready;
    assign push_valid = in_valid;
    assign is_term    = (in_data.rx_byte == CHAR_CR) || (in_data.rx_byte == CHAR_LF);

    always_comb
    begin
        push_cmd.kind      = CMD_NONE;
        push_cmd.set_speed = 1'b0;
        push_cmd.speed     = SPEED_SLOW;
        push_cmd.ended     = 1'b0;
        line_len_next      = line_len_reg;
        flags_next         = flags_reg;

        unique case (in_data.mode)
            MODE_TICK:  push_cmd.kind = CMD_TICK;
            MODE_PRESS: push_cmd.kind = CMD_PRESS;
            MODE_BYTE:  push_cmd.kind = CMD_BYTE;
            default:    push_cmd.kind = CMD_NONE;
        endcase

        if (in_data.mode == MODE_BYTE) begin
            if (is_term) begin
                push_cmd.ended = 1'b1;
                // first word still alive with the right length wins
                priority if (flags_reg[0] && line_len_reg == LW'(word_len(2'd0)))
                begin
                    push_cmd.set_speed = 1'b1;
                    push_cmd.speed     = SPEED_SLOW;
                end
                else if (flags_reg[1] && line_len_reg == LW'(word_len(2'd1)))
                begin
                    push_cmd.set_speed = 1'b1;
                    push_cmd.speed     = SPEED_MID;
                end
                else if (flags_reg[2] && line_len_reg == LW'(word_len(2'd2)))
                begin
                    push_cmd.set_speed = 1'b1;
                    push_cmd.speed     = SPEED_FAST;
                end
                line_len_next = '0;
                flags_next    = 3'b111;
            end
            else if (line_len_reg >= LW'(LINE_MAX)) begin
                // saturate an overlong line; it matches nothing
                line_len_next = LW'(LINE_MAX);
                flags_next    = 3'b000;
            end
            else begin
                for (int k = 0; k < NUM_SPEEDS; k++) begin
                    if (line_len_reg >= LW'(word_len(2'(k))) ||
                        word_char(2'(k), line_len_reg[1:0]) != in_data.rx_byte)
                    begin
                        flags_next[k] = 1'b0;
                    end
                end
                line_len_next = line_len_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_len_reg <= '0;
            flags_reg    <= 3'b111;
        end
        else if (take) begin
            line_len_reg <= line_len_next;
            flags_reg    <= flags_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lbs_queue.sv
// Short command queue between the front end and the back end.
// Depends on lbs_pkg.
`default_nettype none

module lbs_queue
    import lbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    input  wire lbs_cmd_t push_cmd,
    output logic          push_ready,
    output logic          pop_valid,
    output lbs_cmd_t      pop_cmd,
    input  wire logic     pop_ready
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lbs_cmd_t      slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign push_ready = count_reg != CW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lbs_back.sv
// Back end: time keeping, debounce, speed selection, LED toggle and result register.
// Holds the configuration registers. Depends on lbs_pkg.
`default_nettype none

module lbs_back
    import lbs_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_idx,
    input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
    input  wire logic                 cmd_valid,
    input  wire lbs_cmd_t             cmd,
    output logic                      cmd_ready,
    output logic                      out_valid,
    output lbs_out_t                  out_data,
    input  wire logic                 out_ready
);

    logic [CFG_WIDTH-1:0] slow_reg, mid_reg, fast_reg, debounce_reg;

    // elapsed ticks since the last toggle and since the last accepted press
    logic [TIME_BITS-1:0] since_toggle_reg, since_toggle_next, since_toggle_step;
    logic [TIME_BITS-1:0] since_press_reg, since_press_next;
    logic                 led_reg, led_next;
    speed_t               speed_reg, speed_next;
    logic [CFG_WIDTH-1:0] period;
    logic                 toggle;
    logic                 take;
    logic                 out_valid_reg;
    lbs_out_t             out_data_reg;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        since_toggle_step = since_toggle_reg;
        since_press_next  = since_press_reg;
        speed_next        = speed_reg;

        unique case (cmd.kind)
            CMD_TICK:
            begin
                since_toggle_step = since_toggle_reg + 1'b1;
                since_press_next  = since_press_reg + 1'b1;
            end
            CMD_PRESS:
            begin
                // a press inside the lockout changes nothing
                if (since_press_reg >= TIME_BITS'(debounce_reg)) begin
                    since_toggle_step = '0;
                    since_press_next  = '0;
                    speed_next        = next_speed(speed_reg);
                end
            end
            CMD_BYTE:
            begin
                if (cmd.set_speed) begin
                    speed_next = cmd.speed;
                end
            end
            CMD_NONE:
            begin
            end
        endcase

        unique case (speed_next)
            SPEED_MID:  period = mid_reg;
            SPEED_FAST: period = fast_reg;
            default:    period = slow_reg;
        endcase

        toggle            = since_toggle_step >= TIME_BITS'(period);
        since_toggle_next = toggle ? '0 : since_toggle_step;
        led_next          = led_reg ^ toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slow_reg     <= SLOW_PERIOD_RST;
            mid_reg      <= MID_PERIOD_RST;
            fast_reg     <= FAST_PERIOD_RST;
            debounce_reg <= DEBOUNCE_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_SLOW_PERIOD: slow_reg     <= cfg_wdata;
                REG_MID_PERIOD:  mid_reg      <= cfg_wdata;
                REG_FAST_PERIOD: fast_reg     <= cfg_wdata;
                REG_DEBOUNCE:    debounce_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            since_toggle_reg <= '0;
            since_press_reg  <= '0;
            led_reg          <= 1'b0;
            speed_reg        <= SPEED_SLOW;
            out_valid_reg    <= 1'b0;
        end
        else begin
            if (take) begin
                since_toggle_reg <= since_toggle_next;
                since_press_reg  <= since_press_next;
                led_reg          <= led_next;
                speed_reg        <= speed_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            out_data_reg.led_on      <= led_next;
            out_data_reg.speed_code  <= speed_next;
            out_data_reg.led_toggled <= toggle;
            out_data_reg.line_ended  <= cmd.ended;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lbs_checker.sv
// Port-level checks for the LED blink speed controller, bound to the top level.
// Depends on lbs_pkg.
`default_nettype none

module lbs_checker
    import lbs_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire lbs_out_t out_data
);

    logic [2:0] pending_reg;
    logic       led_reg;
    logic       in_take, out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // track words in flight and the last LED level delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= '0;
            led_reg     <= 1'b0;
        end
        else begin
            if (in_take && !out_take) begin
                pending_reg <= pending_reg + 1'b1;
            end
            else if (out_take && !in_take) begin
                pending_reg <= pending_reg - 1'b1;
            end
            if (out_take) begin
                led_reg <= out_data.led_on;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result shown with no word outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> pending_reg <= 3'd2)
        else $error("word accepted beyond queue and result capacity");

    a_led_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> out_data.led_on == (led_reg ^ out_data.led_toggled))
        else $error("LED level inconsistent with toggle flag");

endmodule

bind led_blink_speed_controller lbs_checker u_lbs_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_blink_speed_controller: ticks, presses and serial lines
// against an in-bench blink/speed predictor. Depends on lbs_pkg and the block's top level.

module tb;
    import lbs_pkg::*;

    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLD_OFF_TICKS = 400;
    localparam int HOLD_OFF_AT    = 700;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    logic [1:0] cfg_idx = REG_SLOW_PERIOD;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    lbs_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    lbs_out_t out_data;

    led_blink_speed_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Bench copy of the registers and of the blink/line state
    logic [15:0] cfg_copy [4] = '{SLOW_PERIOD_RST, MID_PERIOD_RST, FAST_PERIOD_RST,
                                  DEBOUNCE_RST};
    logic [31:0] led_ticks      = '0;
    logic [31:0] last_toggle_at = '0;
    logic [31:0] last_press_at  = '0;
    logic        led_lit        = 1'b0;
    speed_t      speed_now      = SPEED_SLOW;
    logic [6:0]  line_len       = '0;
    logic [2:0]  line_flags     = 3'b111;

    logic [7:0] word_chars [3][4] = '{'{"s", "l", "o", "w"},
                                      '{"m", "i", "d", 8'h00},
                                      '{"f", "a", "s", "t"}};
    int word_lens [3] = '{4, 3, 4};

    lbs_in_t  events_to_send [$];
    lbs_out_t led_results_due [$];

    int events_outstanding = 0;
    int events_queued      = 0;
    int results_seen       = 0;
    int mismatches         = 0;
    int toggles_seen       = 0;
    int presses_taken      = 0;
    int words_matched      = 0;
    int overlong_lines     = 0;
    int quiet_cycles       = 0;

    int   send_wait    = 0;
    logic send_steady  = 1'b0;
    int   recv_wait    = 0;
    logic recv_steady  = 1'b0;
    int   hold_left    = 0;
    logic pressure_done = 1'b0;
    lbs_out_t due;

    function automatic lbs_out_t led_event_outcome(input lbs_in_t ev);
        lbs_out_t    res;
        logic [15:0] period;
        logic        hit;
        res = '0;
        hit = 1'b0;
        case (ev.mode)
            MODE_TICK:
                led_ticks = led_ticks + 32'd1;
            MODE_PRESS:
                if (led_ticks - last_press_at >= {16'd0, cfg_copy[REG_DEBOUNCE]}) begin
                    last_press_at  = led_ticks;
                    last_toggle_at = led_ticks;
                    case (speed_now)
                        SPEED_SLOW: speed_now = SPEED_MID;
                        SPEED_MID:  speed_now = SPEED_FAST;
                        default:    speed_now = SPEED_SLOW;
                    endcase
                    presses_taken++;
                end
            MODE_BYTE:
                if (ev.rx_byte == CHAR_CR || ev.rx_byte == CHAR_LF) begin
                    res.line_ended = 1'b1;
                    // first word still possible with the right length wins
                    for (int k = 0; k < NUM_SPEEDS; k++) begin
                        if (!hit && line_flags[k] && line_len == word_lens[k]) begin
                            speed_now = speed_t'(k);
                            hit = 1'b1;
                            words_matched++;
                        end
                    end
                    line_len   = '0;
                    line_flags = 3'b111;
                end else if (line_len >= LINE_MAX_DEF) begin
                    line_len   = 7'(LINE_MAX_DEF);
                    line_flags = '0;
                end else begin
                    for (int k = 0; k < NUM_SPEEDS; k++) begin
                        if (line_len >= word_lens[k])
                            line_flags[k] = 1'b0;
                        else if (word_chars[k][line_len[1:0]] != ev.rx_byte)
                            line_flags[k] = 1'b0;
                    end
                    line_len = line_len + 7'd1;
                end
            default: ;
        endcase
        case (speed_now)
            SPEED_MID:  period = cfg_copy[REG_MID_PERIOD];
            SPEED_FAST: period = cfg_copy[REG_FAST_PERIOD];
            default:    period = cfg_copy[REG_SLOW_PERIOD];
        endcase
        if (led_ticks - last_toggle_at >= {16'd0, period}) begin
            led_lit        = ~led_lit;
            last_toggle_at = led_ticks;
            res.led_toggled = 1'b1;
        end
        res.led_on     = led_lit;
        res.speed_code = speed_now;
        return res;
    endfunction

    task automatic queue_event(input logic [1:0] kind, input logic [7:0] ch);
        lbs_in_t ev;
        ev.mode    = kind;
        ev.rx_byte = ch;
        events_to_send.push_back(ev);
        events_queued++;
        events_outstanding++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_event(MODE_BYTE, s[i]);
    endtask

    task automatic put_reg(input cfg_reg_t r, input logic [15:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= r;
        cfg_wdata <= v;
        cfg_copy[r] = v;
    endtask

    task automatic program_periods(input logic [15:0] slow_p, input logic [15:0] mid_p,
                                   input logic [15:0] fast_p, input logic [15:0] lockout);
        put_reg(REG_SLOW_PERIOD, slow_p);
        put_reg(REG_MID_PERIOD, mid_p);
        put_reg(REG_FAST_PERIOD, fast_p);
        put_reg(REG_DEBOUNCE, lockout);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (events_outstanding != 0)
            @(posedge clk);
        // let the block settle before touching registers
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] line_char();
        int k;
        k = $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return word_chars[k][$urandom_range(0, word_lens[k] - 1)];
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    task automatic add_random_events(input int target);
        int start;
        int pick;
        int k;
        int n;
        start = events_queued;
        while (events_queued - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
                repeat ($urandom_range(1, 25))
                    queue_event(MODE_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 52) begin
                queue_event(MODE_PRESS, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 3)) begin
                    repeat ($urandom_range(0, 8))
                        queue_event(MODE_TICK, 8'($urandom_range(0, 255)));
                    queue_event(MODE_PRESS, 8'($urandom_range(0, 255)));
                end
            end else if (pick < 77) begin
                // well-formed speed word, ticks may fall between its characters
                k = $urandom_range(0, 2);
                for (int i = 0; i < word_lens[k]; i++) begin
                    if ($urandom_range(0, 3) == 0)
                        queue_event(MODE_TICK, 8'($urandom_range(0, 255)));
                    queue_event(MODE_BYTE, word_chars[k][i]);
                end
                queue_event(MODE_BYTE, line_end());
            end else if (pick < 88) begin
                n = $urandom_range(0, 6);
                repeat (n) queue_event(MODE_BYTE, line_char());
                queue_event(MODE_BYTE, line_end());
            end else if (pick < 93) begin
                n = $urandom_range(60, 70);
                repeat (n) queue_event(MODE_BYTE, line_char());
                if (n > LINE_MAX_DEF)
                    overlong_lines++;
                queue_event(MODE_BYTE, line_end());
            end else begin
                queue_event(MODE_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Driver: hold each word until taken, then draw the gap before the next one
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && in_ready) begin
                led_results_due.push_back(led_event_outcome(in_data));
                send_wait = send_steady ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 63) == 0)
                    send_steady = ~send_steady;
            end
            if (!in_valid || in_ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (events_to_send.size() != 0) begin
                    in_data  <= events_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endtask

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (led_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 40)
                        $display("%0t ns: unexpected result, expected none, actual %p",
                                 $time, out_data);
                end else begin
                    due = led_results_due.pop_front();
                    check_field("led_on", due.led_on, out_data.led_on);
                    check_field("speed_code", due.speed_code, out_data.speed_code);
                    check_field("led_toggled", due.led_toggled, out_data.led_toggled);
                    check_field("line_ended", due.line_ended, out_data.line_ended);
                    events_outstanding--;
                end
                if (out_data.led_toggled)
                    toggles_seen++;
                if (!pressure_done && results_seen == HOLD_OFF_AT) begin
                    // long back-pressure so the block fills and stalls its input
                    hold_left     = HOLD_OFF_TICKS;
                    pressure_done = 1'b1;
                end
                recv_wait = recv_steady ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 63) == 0)
                    recv_steady = ~recv_steady;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: byte extremes, both terminators, empty line, NUL after a word
        queue_event(MODE_TICK, 8'hFF);
        queue_event(MODE_PRESS, 8'h00);
        queue_text("mid");
        queue_event(MODE_BYTE, CHAR_CR);
        queue_text("fast");
        queue_event(MODE_BYTE, CHAR_LF);
        queue_event(MODE_BYTE, CHAR_LF);
        queue_text("slow");
        queue_event(MODE_BYTE, 8'h00);
        queue_event(MODE_BYTE, CHAR_CR);
        queue_text("slow");
        queue_event(MODE_BYTE, CHAR_CR);
        queue_event(MODE_BYTE, 8'hFF);
        queue_event(MODE_BYTE, CHAR_LF);
        wait_drained();

        program_periods(16'd12, 16'd7, 16'd3, 16'd5);
        add_random_events(500);
        wait_drained();

        program_periods(16'd1, 16'd1, 16'd1, 16'd0);
        add_random_events(250);
        wait_drained();

        program_periods(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random_events(150);
        wait_drained();

        program_periods(16'($urandom_range(1, 40)), 16'($urandom_range(1, 25)),
                        16'($urandom_range(1, 12)), 16'($urandom_range(0, 15)));
        add_random_events(450);
        wait_drained();

        program_periods(16'($urandom_range(100, 3000)), 16'($urandom_range(1, 60)),
                        16'($urandom_range(1, 8)), 16'($urandom_range(0, 200)));
        add_random_events(400);
        wait_drained();

        repeat (10) @(posedge clk);
        if (led_results_due.size() != 0) begin
            mismatches++;
            $display("%0t ns: %0d results never arrived", $time, led_results_due.size());
        end

        $display("Sent %0d events over six register settings, checked %0d results.",
                 events_queued, results_seen);
        $display("Saw %0d LED toggles, %0d presses taken, %0d speed words, %0d over-long lines.",
                 toggles_seen, presses_taken, words_matched, overlong_lines);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
